### hw/rtl/timestamped_pin_debounce_qualifier_assert.svh
// ----------------------------------------------------------------------------
// Timestamped pin debounce qualifier assertion macros
// Shared concurrent assertion forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef TIMESTAMPED_PIN_DEBOUNCE_QUALIFIER_ASSERT_SVH
`define TIMESTAMPED_PIN_DEBOUNCE_QUALIFIER_ASSERT_SVH

// Assertion that is checked only while reset is released.
`define TPDQ_ASSERT_RUN(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("tpdq assertion failed");

// Assertion that is checked on every clock edge, reset included.
`define TPDQ_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge i_clk) prop) \
        else $error("tpdq assertion failed");

`endif

### hw/rtl/tpdq_pkg.sv
// ----------------------------------------------------------------------------
// Timestamped pin debounce qualifier package
// Item types, configuration types, codes and reset values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tpdq_pkg;

    localparam int unsigned TimeW  = 32;
    localparam int unsigned CountW = 32;
    localparam int unsigned DebW   = 16;
    localparam int unsigned CfgIdxW = 2;
    localparam int unsigned CfgDataW = 32;

    typedef enum logic [1:0] {
        EV_UNCHANGED = 2'd0,
        EV_MATCH     = 2'd1,
        EV_UNMATCH   = 2'd2,
        EV_SPURIOUS  = 2'd3
    } t_event_kind;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_DEBOUNCE_MS    = 2'd0,
        CFG_MAX_MATCHED_MS = 2'd1,
        CFG_MATCH_LEVEL    = 2'd2
    } t_cfg_index;

    localparam logic [DebW-1:0]  DebounceReset   = 16'd50;
    localparam logic [TimeW-1:0] MaxMatchedReset = 32'd0;
    localparam logic             MatchLevelReset = 1'b1;

    typedef struct packed {
        logic             level;
        logic [TimeW-1:0] now_ms;
    } t_in_item;

    typedef struct packed {
        logic              matched;
        logic [1:0]        event_kind;
        logic [TimeW-1:0]  matched_duration;
        logic [CountW-1:0] invoked_count;
        logic [CountW-1:0] match_count;
        logic [CountW-1:0] unmatch_count;
        logic [CountW-1:0] spurious_count;
        logic [CountW-1:0] unchanged_count;
    } t_out_item;

    typedef struct packed {
        logic [DebW-1:0]  debounce_ms;
        logic [TimeW-1:0] max_matched_ms;
        logic             match_level;
    } t_cfg;

endpackage

`default_nettype wire

### hw/rtl/tpdq_cfg_regs.sv
// ----------------------------------------------------------------------------
// Timestamped pin debounce qualifier configuration registers
// Holds debounce time, maximum matched time and match level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tpdq_cfg_regs (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_valid,
    input  wire logic [tpdq_pkg::CfgIdxW-1:0]    i_cfg_index,
    input  wire logic [tpdq_pkg::CfgDataW-1:0]   i_cfg_data,
    output tpdq_pkg::t_cfg                       o_cfg
);

    tpdq_pkg::t_cfg r_cfg;
    tpdq_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (tpdq_pkg::t_cfg_index'(i_cfg_index))
                tpdq_pkg::CFG_DEBOUNCE_MS: begin
                    n_cfg.debounce_ms = i_cfg_data[tpdq_pkg::DebW-1:0];
                end
                tpdq_pkg::CFG_MAX_MATCHED_MS: begin
                    n_cfg.max_matched_ms = i_cfg_data[tpdq_pkg::TimeW-1:0];
                end
                tpdq_pkg::CFG_MATCH_LEVEL: begin
                    n_cfg.match_level = i_cfg_data[0];
                end
                default: begin
                    n_cfg = r_cfg;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ms    <= tpdq_pkg::DebounceReset;
            r_cfg.max_matched_ms <= tpdq_pkg::MaxMatchedReset;
            r_cfg.match_level    <= tpdq_pkg::MatchLevelReset;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

### hw/rtl/tpdq_eval.sv
// ----------------------------------------------------------------------------
// Timestamped pin debounce qualifier evaluation stage
// Judges one pin event against the stored state and updates the counters.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tpdq_eval (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_step,
    input  wire tpdq_pkg::t_in_item i_item,
    input  wire tpdq_pkg::t_cfg   i_cfg,
    output tpdq_pkg::t_out_item o_result
);

    logic                               r_prev_level;
    logic [tpdq_pkg::TimeW-1:0]         r_prev_time;
    logic                               r_matched;
    logic [tpdq_pkg::TimeW-1:0]         r_duration;
    logic [tpdq_pkg::CountW-1:0]        r_events;
    logic [tpdq_pkg::CountW-1:0]        r_matches;
    logic [tpdq_pkg::CountW-1:0]        r_unmatches;
    logic [tpdq_pkg::CountW-1:0]        r_spurious;
    logic [tpdq_pkg::CountW-1:0]        r_repeats;

    logic                               n_matched;
    logic [tpdq_pkg::TimeW-1:0]         n_duration;
    logic [tpdq_pkg::CountW-1:0]        n_events;
    logic [tpdq_pkg::CountW-1:0]        n_matches;
    logic [tpdq_pkg::CountW-1:0]        n_unmatches;
    logic [tpdq_pkg::CountW-1:0]        n_spurious;
    logic [tpdq_pkg::CountW-1:0]        n_repeats;

    logic                               w_changed;
    logic [tpdq_pkg::TimeW-1:0]         w_elapsed;
    logic                               w_settled;
    logic                               w_to_match;
    logic                               w_within;
    tpdq_pkg::t_event_kind              w_kind;

    assign w_changed  = i_item.level != r_prev_level;
    assign w_elapsed  = i_item.now_ms - r_prev_time;
    assign w_settled  = w_elapsed >= {{(tpdq_pkg::TimeW-tpdq_pkg::DebW){1'b0}},
                                      i_cfg.debounce_ms};
    assign w_to_match = i_item.level == i_cfg.match_level;
    assign w_within   = (i_cfg.max_matched_ms == '0) || (w_elapsed < i_cfg.max_matched_ms);

    always_comb begin
        if (!w_changed) begin
            w_kind = tpdq_pkg::EV_UNCHANGED;
        end else if (!w_settled) begin
            w_kind = tpdq_pkg::EV_SPURIOUS;
        end else if (w_to_match) begin
            w_kind = tpdq_pkg::EV_MATCH;
        end else if (w_within) begin
            w_kind = tpdq_pkg::EV_UNMATCH;
        end else begin
            w_kind = tpdq_pkg::EV_SPURIOUS;
        end
    end

    // A settled change sets or clears the flag even when the maximum time is exceeded.
    assign n_matched   = (w_changed && w_settled) ? w_to_match : r_matched;
    assign n_duration  = (w_kind == tpdq_pkg::EV_UNMATCH) ? w_elapsed : r_duration;
    assign n_events    = r_events + {{(tpdq_pkg::CountW-1){1'b0}}, 1'b1};
    assign n_matches   = r_matches + {{(tpdq_pkg::CountW-1){1'b0}},
                                      w_kind == tpdq_pkg::EV_MATCH};
    assign n_unmatches = r_unmatches + {{(tpdq_pkg::CountW-1){1'b0}},
                                        w_kind == tpdq_pkg::EV_UNMATCH};
    assign n_spurious  = r_spurious + {{(tpdq_pkg::CountW-1){1'b0}},
                                       w_kind == tpdq_pkg::EV_SPURIOUS};
    assign n_repeats   = r_repeats + {{(tpdq_pkg::CountW-1){1'b0}}, !w_changed};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_level <= 1'b0;
            r_prev_time  <= '0;
            r_matched    <= 1'b0;
            r_duration   <= '0;
            r_events     <= '0;
            r_matches    <= '0;
            r_unmatches  <= '0;
            r_spurious   <= '0;
            r_repeats    <= '0;
        end else if (i_step) begin
            if (w_changed) begin
                r_prev_level <= i_item.level;
                r_prev_time  <= i_item.now_ms;
            end
            r_matched   <= n_matched;
            r_duration  <= n_duration;
            r_events    <= n_events;
            r_matches   <= n_matches;
            r_unmatches <= n_unmatches;
            r_spurious  <= n_spurious;
            r_repeats   <= n_repeats;
        end
    end

    always_comb begin
        o_result.matched          = n_matched;
        o_result.event_kind       = w_kind;
        o_result.matched_duration = n_duration;
        o_result.invoked_count    = n_events;
        o_result.match_count      = n_matches;
        o_result.unmatch_count    = n_unmatches;
        o_result.spurious_count   = n_spurious;
        o_result.unchanged_count  = n_repeats;
    end

endmodule

`default_nettype wire

### hw/rtl/timestamped_pin_debounce_qualifier.sv
// ----------------------------------------------------------------------------
// Timestamped pin debounce qualifier
// Qualifies timestamped pin-change events against a debounce time.
// ----------------------------------------------------------------------------
// Usage: each input item carries a sampled pin level and a 32-bit millisecond
// timestamp, offered on i_in_valid/o_in_ready. Every item yields exactly one
// result item on o_out_valid/i_out_ready with the matched flag, the event kind,
// the last matched duration and all event counters after the update.
// The item is captured in an input register, judged by the evaluation logic,
// and the result is captured in an output register.
// Throughput is one item per cycle while i_out_ready is high; the state update
// is one subtract and two compares, so consecutive items follow without gaps.
// If the receiver stalls, the result is held, the input register still fills,
// and o_in_ready drops only when both registers are occupied.
// Configuration writes on i_cfg_valid are always taken and must be issued
// while no item is in flight.
// Reset clears the valid flags of both pipeline registers, all counters and
// the stored level and time, and restores the configuration reset values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module timestamped_pin_debounce_qualifier (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire tpdq_pkg::t_in_item            i_in_item,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output tpdq_pkg::t_out_item                o_out_item,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [tpdq_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  wire logic [tpdq_pkg::CfgDataW-1:0] i_cfg_data
);

    logic                r_in_valid;
    tpdq_pkg::t_in_item  r_in_item;
    logic                r_out_valid;
    tpdq_pkg::t_out_item r_out_item;

    logic                w_advance;
    tpdq_pkg::t_cfg      w_cfg;
    tpdq_pkg::t_out_item w_result;

    assign w_advance   = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || w_advance;
    assign o_cfg_ready = 1'b1;

    tpdq_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    tpdq_eval u_eval (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_advance),
        .i_item   (r_in_item),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_item <= i_in_item;
        end
        if (w_advance) begin
            r_out_item <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

`default_nettype wire

### hw/rtl/tpdq_checker.sv
// ----------------------------------------------------------------------------
// Timestamped pin debounce qualifier checker
// Port-level assertions on result items, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "timestamped_pin_debounce_qualifier_assert.svh"

module tpdq_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          o_out_valid,
    input  wire logic                          i_out_ready,
    input  wire tpdq_pkg::t_out_item           o_out_item
);

    logic [tpdq_pkg::CountW-1:0] w_kind_sum;
    logic                        w_stalled;
    logic                        w_is_match;
    logic                        w_is_unmatch;

    assign w_kind_sum = o_out_item.match_count + o_out_item.unmatch_count
                      + o_out_item.spurious_count + o_out_item.unchanged_count;
    assign w_stalled    = o_out_valid && !i_out_ready;
    assign w_is_match   = o_out_valid && (o_out_item.event_kind == tpdq_pkg::EV_MATCH);
    assign w_is_unmatch = o_out_valid && (o_out_item.event_kind == tpdq_pkg::EV_UNMATCH);

    `TPDQ_ASSERT_ALWAYS(a_no_item_after_reset, !i_rst_n |=> !o_out_valid)
    `TPDQ_ASSERT_RUN(a_stall_holds, w_stalled |=> o_out_valid && $stable(o_out_item))
    `TPDQ_ASSERT_RUN(a_counts_add_up, o_out_valid |-> w_kind_sum == o_out_item.invoked_count)
    `TPDQ_ASSERT_RUN(a_match_sets_flag, w_is_match |-> o_out_item.matched)
    `TPDQ_ASSERT_RUN(a_unmatch_clears_flag, w_is_unmatch |-> !o_out_item.matched)

endmodule

bind timestamped_pin_debounce_qualifier tpdq_checker u_checker (.*);

`default_nettype wire

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// Testbench for the timestamped pin debounce qualifier
// A queue of pin-change items and register writes feeds a clocked driver,
// and a clocked monitor checks every result item against a predictor of the
// debounce rules. Both sides idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    localparam int unsigned SettleCycles = 4;
    localparam int unsigned DrainCycles  = 8;
    localparam logic [tpdq_pkg::CfgIdxW-1:0] CfgUnusedIdx = 2'd3;

    typedef enum logic [1:0] {
        OP_EVENT,
        OP_REG_WRITE,
        OP_QUIESCE
    } t_op;

    typedef struct {
        t_op                           op;
        tpdq_pkg::t_in_item            item;
        logic [tpdq_pkg::CfgIdxW-1:0]  index;
        logic [tpdq_pkg::CfgDataW-1:0] data;
    } t_stim;

    logic                          i_clk       = 1'b0;
    logic                          i_rst_n     = 1'b0;
    logic                          in_valid    = 1'b0;
    tpdq_pkg::t_in_item            in_item     = '0;
    logic                          out_ready   = 1'b0;
    logic                          cfg_valid   = 1'b0;
    logic [tpdq_pkg::CfgIdxW-1:0]  cfg_index   = '0;
    logic [tpdq_pkg::CfgDataW-1:0] cfg_data    = '0;
    logic                          o_in_ready;
    logic                          o_out_valid;
    tpdq_pkg::t_out_item           o_out_item;
    logic                          o_cfg_ready;

    t_stim               stim_queue[$];
    tpdq_pkg::t_out_item predicted_outcomes[$];
    int unsigned events_sent    = 0;
    int unsigned outcomes_seen  = 0;
    int unsigned mismatch_count = 0;
    logic        stim_done      = 1'b0;

    // Predictor state and its copy of the registers.
    tpdq_pkg::t_cfg pred_cfg;
    logic        pred_level;
    logic [31:0] pred_change_ms;
    logic        pred_matched;
    logic [31:0] pred_duration;
    logic [31:0] pred_events;
    logic [31:0] pred_matches;
    logic [31:0] pred_unmatches;
    logic [31:0] pred_spurious;
    logic [31:0] pred_repeats;

    // Stimulus generator view of the stored level and change time.
    logic        gen_level  = 1'b0;
    logic [31:0] gen_change = '0;
    logic [31:0] gen_now    = '0;

    timestamped_pin_debounce_qualifier dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void apply_register(logic [tpdq_pkg::CfgIdxW-1:0] idx,
                                           logic [tpdq_pkg::CfgDataW-1:0] data);
        case (idx)
            tpdq_pkg::CFG_DEBOUNCE_MS:
                pred_cfg.debounce_ms    = data[tpdq_pkg::DebW-1:0];
            tpdq_pkg::CFG_MAX_MATCHED_MS:
                pred_cfg.max_matched_ms = data;
            tpdq_pkg::CFG_MATCH_LEVEL:
                pred_cfg.match_level    = data[0];
            default: ;
        endcase
    endfunction

    function automatic tpdq_pkg::t_out_item qualify_event(tpdq_pkg::t_in_item it);
        tpdq_pkg::t_out_item   res;
        tpdq_pkg::t_event_kind kind;
        logic [31:0]           elapsed;
        kind = tpdq_pkg::EV_UNCHANGED;
        pred_events = pred_events + 1;
        if (it.level != pred_level) begin
            elapsed = it.now_ms - pred_change_ms;
            if (elapsed < {16'd0, pred_cfg.debounce_ms}) begin
                kind = tpdq_pkg::EV_SPURIOUS;
            end else if (it.level == pred_cfg.match_level) begin
                pred_matched = 1'b1;
                kind = tpdq_pkg::EV_MATCH;
            end else begin
                pred_matched = 1'b0;
                if (pred_cfg.max_matched_ms == 0 || elapsed < pred_cfg.max_matched_ms) begin
                    pred_duration = elapsed;
                    kind = tpdq_pkg::EV_UNMATCH;
                end else begin
                    kind = tpdq_pkg::EV_SPURIOUS;
                end
            end
            case (kind)
                tpdq_pkg::EV_MATCH:   pred_matches   = pred_matches + 1;
                tpdq_pkg::EV_UNMATCH: pred_unmatches = pred_unmatches + 1;
                default:              pred_spurious  = pred_spurious + 1;
            endcase
            pred_change_ms = it.now_ms;
            pred_level = it.level;
        end else begin
            pred_repeats = pred_repeats + 1;
        end
        res.matched          = pred_matched;
        res.event_kind       = kind;
        res.matched_duration = pred_duration;
        res.invoked_count    = pred_events;
        res.match_count      = pred_matches;
        res.unmatch_count    = pred_unmatches;
        res.spurious_count   = pred_spurious;
        res.unchanged_count  = pred_repeats;
        return res;
    endfunction

    function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            mismatch_count = mismatch_count + 1;
            $display("%0t %s expected %0h actual %0h", $time, field, want, got);
        end
    endfunction

    task automatic add_event(logic level, logic [31:0] now_ms);
        t_stim s;
        s.op = OP_EVENT;
        s.item.level = level;
        s.item.now_ms = now_ms;
        s.index = '0;
        s.data = '0;
        stim_queue.push_back(s);
        if (level != gen_level) begin
            gen_level = level;
            gen_change = now_ms;
        end
        gen_now = now_ms;
    endtask

    task automatic add_write(logic [tpdq_pkg::CfgIdxW-1:0] idx,
                             logic [tpdq_pkg::CfgDataW-1:0] data);
        t_stim s;
        s.op = OP_REG_WRITE;
        s.item = '0;
        s.index = idx;
        s.data = data;
        stim_queue.push_back(s);
    endtask

    task automatic add_quiesce();
        t_stim s;
        s.op = OP_QUIESCE;
        s.item = '0;
        s.index = '0;
        s.data = '0;
        stim_queue.push_back(s);
    endtask

    // Most items are level changes timed near the debounce and maximum limits.
    task automatic add_random_event(logic [31:0] deb, logic [31:0] mx);
        logic [31:0] delta;
        if ($urandom_range(0, 3) == 0) begin
            if ($urandom_range(0, 1) == 0) begin
                add_event(gen_level, $urandom());
            end else begin
                add_event(gen_level, gen_now + $urandom_range(0, 100));
            end
        end else begin
            case ($urandom_range(0, 9))
                0: delta = 0;
                1: delta = $urandom_range(0, deb);
                2: delta = deb - 1;
                3: delta = deb;
                4: delta = deb + $urandom_range(0, 300);
                5: delta = (mx == 0) ? deb + 1 : mx - 1;
                6: delta = (mx == 0) ? $urandom() : mx;
                7: delta = $urandom();
                default: delta = deb + $urandom_range(0, 2000);
            endcase
            add_event(~gen_level, gen_change + delta);
        end
    endtask

    // Driver: presents queued items and register writes, predicts on acceptance.
    int unsigned gap_left  = 0;
    int unsigned in_calm   = 0;
    int unsigned quiet     = 0;

    always @(posedge i_clk) begin : driver
        logic in_fire;
        logic cfg_fire;
        logic idle;
        in_fire  = in_valid && o_in_ready;
        cfg_fire = cfg_valid && o_cfg_ready;
        if (in_fire || events_sent != outcomes_seen) begin
            quiet = 0;
        end else if (quiet < 1000) begin
            quiet = quiet + 1;
        end
        idle = !in_fire && events_sent == outcomes_seen && quiet >= SettleCycles;
        if (in_fire) begin
            predicted_outcomes.push_back(qualify_event(in_item));
            events_sent <= events_sent + 1;
            if (in_calm > 0) begin
                in_calm = in_calm - 1;
                gap_left = 0;
            end else if ($urandom_range(0, 15) == 0) begin
                in_calm = $urandom_range(10, 40);
                gap_left = 0;
            end else begin
                gap_left = $urandom_range(0, 15);
            end
        end
        if (cfg_fire) begin
            apply_register(cfg_index, cfg_data);
        end
        if (i_rst_n) begin
            if ((in_valid && !in_fire) || (cfg_valid && !cfg_fire)) begin
                // Hold the offered item or write until it is taken.
            end else if (gap_left > 0) begin
                gap_left = gap_left - 1;
                in_valid <= 1'b0;
                cfg_valid <= 1'b0;
            end else if (stim_queue.size() == 0) begin
                in_valid <= 1'b0;
                cfg_valid <= 1'b0;
                stim_done <= 1'b1;
            end else begin
                case (stim_queue[0].op)
                    OP_EVENT: begin
                        in_valid <= 1'b1;
                        in_item <= stim_queue[0].item;
                        cfg_valid <= 1'b0;
                        void'(stim_queue.pop_front());
                    end
                    OP_REG_WRITE: begin
                        in_valid <= 1'b0;
                        if (idle) begin
                            cfg_valid <= 1'b1;
                            cfg_index <= stim_queue[0].index;
                            cfg_data <= stim_queue[0].data;
                            void'(stim_queue.pop_front());
                        end else begin
                            cfg_valid <= 1'b0;
                        end
                    end
                    default: begin
                        in_valid <= 1'b0;
                        cfg_valid <= 1'b0;
                        if (idle) begin
                            void'(stim_queue.pop_front());
                        end
                    end
                endcase
            end
        end
    end

    // Monitor: stalls at random and checks each result item.
    int unsigned stall_left = 0;
    int unsigned out_calm   = 0;

    always @(posedge i_clk) begin : monitor
        tpdq_pkg::t_out_item want;
        if (i_rst_n) begin
            if (o_out_valid && out_ready) begin
                outcomes_seen <= outcomes_seen + 1;
                if (predicted_outcomes.size() == 0) begin
                    mismatch_count = mismatch_count + 1;
                    $display("%0t unexpected result item %0h", $time, o_out_item);
                end else begin
                    want = predicted_outcomes.pop_front();
                    check_field("matched", want.matched, o_out_item.matched);
                    check_field("event_kind", want.event_kind, o_out_item.event_kind);
                    check_field("matched_duration", want.matched_duration,
                                o_out_item.matched_duration);
                    check_field("invoked_count", want.invoked_count, o_out_item.invoked_count);
                    check_field("match_count", want.match_count, o_out_item.match_count);
                    check_field("unmatch_count", want.unmatch_count, o_out_item.unmatch_count);
                    check_field("spurious_count", want.spurious_count,
                                o_out_item.spurious_count);
                    check_field("unchanged_count", want.unchanged_count,
                                o_out_item.unchanged_count);
                end
                if (out_calm > 0) begin
                    out_calm = out_calm - 1;
                    stall_left = 0;
                end else if ($urandom_range(0, 15) == 0) begin
                    out_calm = $urandom_range(10, 40);
                    stall_left = 0;
                end else begin
                    stall_left = $urandom_range(0, 15);
                end
            end
            if (stall_left > 0) begin
                stall_left = stall_left - 1;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    initial begin
        logic [31:0]         deb;
        logic [31:0]         mx;
        logic                ml;
        tpdq_pkg::t_out_item left;
        pred_cfg.debounce_ms    = tpdq_pkg::DebounceReset;
        pred_cfg.max_matched_ms = tpdq_pkg::MaxMatchedReset;
        pred_cfg.match_level    = tpdq_pkg::MatchLevelReset;
        pred_level     = 1'b0;
        pred_change_ms = '0;
        pred_matched   = 1'b0;
        pred_duration  = '0;
        pred_events    = '0;
        pred_matches   = '0;
        pred_unmatches = '0;
        pred_spurious  = '0;
        pred_repeats   = '0;

        // Directed items under the reset settings, then under edge settings.
        add_event(1'b0, 32'd10);
        add_event(1'b1, 32'd20);
        add_event(1'b0, 32'd100);
        add_event(1'b1, 32'd200);
        add_event(1'b0, 32'd210);
        add_event(1'b1, 32'd300);
        add_event(1'b1, 32'hFFFF_FFFF);
        add_event(1'b0, 32'd349);
        add_event(1'b1, 32'd399);
        add_quiesce();
        add_write(tpdq_pkg::CFG_MAX_MATCHED_MS, 32'd100);
        add_event(1'b0, 32'd499);
        add_event(1'b1, 32'd600);
        add_event(1'b0, 32'd699);
        add_event(1'b1, 32'hFFFF_FFF0);
        add_event(1'b0, 32'h0000_0040);
        add_event(1'b1, 32'h0000_0010);
        add_event(1'b0, 32'h0000_0020);
        add_write(tpdq_pkg::CFG_DEBOUNCE_MS, 32'hFFFF_0000);
        add_write(tpdq_pkg::CFG_MATCH_LEVEL, 32'hFFFF_FFFE);
        add_write(tpdq_pkg::CFG_MAX_MATCHED_MS, 32'hFFFF_FFFF);
        add_write(CfgUnusedIdx, $urandom());
        add_event(1'b1, 32'h0000_0020);
        add_event(1'b0, 32'h0000_0020);
        add_event(1'b1, 32'h0000_0030);
        add_write(tpdq_pkg::CFG_DEBOUNCE_MS, 32'h0000_FFFF);
        add_event(1'b0, 32'h0001_002E);
        add_event(1'b1, 32'h0002_002E);

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin deb = $urandom_range(1, 200); mx = 0; ml = 1'b1; end
                1: begin deb = 0; mx = 32'hFFFF_FFFF; ml = 1'b0; end
                2: begin deb = 32'd65535; mx = 0; ml = 1'b1; end
                3: begin
                    deb = $urandom_range(0, 500);
                    mx = deb + $urandom_range(1, 400);
                    ml = 1'($urandom_range(0, 1));
                end
                4: begin deb = $urandom_range(0, 65535); mx = $urandom(); ml = 1'b1; end
                default: begin deb = $urandom_range(0, 3); mx = 1; ml = 1'b0; end
            endcase
            add_write(tpdq_pkg::CFG_DEBOUNCE_MS, {16'($urandom()), deb[15:0]});
            add_write(tpdq_pkg::CFG_MAX_MATCHED_MS, mx);
            add_write(tpdq_pkg::CFG_MATCH_LEVEL, {31'($urandom()), ml});
            if (ph == 3) begin
                add_write(CfgUnusedIdx, $urandom());
            end
            for (int n = 0; n < 106; n++) begin
                if (n == 53) begin
                    add_quiesce();
                end
                add_random_event(deb, mx);
            end
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (stim_done && events_sent == outcomes_seen);
        repeat (DrainCycles) @(posedge i_clk);
        while (predicted_outcomes.size() != 0) begin
            left = predicted_outcomes.pop_front();
            mismatch_count = mismatch_count + 1;
            $display("%0t missing result item, expected %0h", $time, left);
        end
        if (mismatch_count == 0) begin
            $display("timestamped_pin_debounce_qualifier regression: pass");
        end else begin
            $display("timestamped_pin_debounce_qualifier regression: fail");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("timestamped_pin_debounce_qualifier regression: fail");
        $finish;
    end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/tpdq_pkg.sv
hw/rtl/tpdq_cfg_regs.sv
hw/rtl/tpdq_eval.sv
hw/rtl/timestamped_pin_debounce_qualifier.sv
hw/rtl/tpdq_checker.sv
verif/tb_top.sv
